[rtl/ctg_pkg.sv]
// Shared constants and types of the combination task generator.
`timescale 1ns / 1ps
`default_nettype none

package ctg_pkg;

    localparam int MAX_LEN     = 16;
    localparam int TABLE_DEPTH = 256;

    localparam int DATA_W  = 32;
    localparam int LEN_W   = 5;
    localparam int OS_W    = 9;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int POS_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SIZE_W = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W  = (CNT_W > OS_W) ? CNT_W : OS_W;
    localparam int IDXC_W = IDX_W + 1;

    // register select, taken from paddr[2]
    localparam logic [0:0] REG_MAX_LENGTH = 1'b0;
    localparam logic [0:0] REG_OUT_START  = 1'b1;

    // input transaction kind
    localparam logic KIND_APPEND  = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // access to the index vector store
    typedef struct packed {
        logic             rd_en;
        logic [POS_W-1:0] rd_addr;
        logic             wr_en;
        logic [POS_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
        logic             clear;
    } t_idx_req;

endpackage

`default_nettype wire

[rtl/ctg_idx_mem.sv]
// Index vector store: one-port memory with per-entry valid bits and restart values.
`timescale 1ns / 1ps
`default_nettype none

module ctg_idx_mem (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ctg_pkg::t_idx_req           i_req,
    input  wire logic [ctg_pkg::SIZE_W-1:0]  i_cur_size,
    input  wire logic [ctg_pkg::OS_W-1:0]    i_out_start,
    output logic      [ctg_pkg::IDX_W-1:0]   o_rd_value
);
    import ctg_pkg::*;

    logic [IDX_W-1:0] r_mem [MAX_LEN];
    logic [MAX_LEN-1:0] r_valid;
    logic [IDX_W-1:0] r_rd_data;
    logic             r_rd_hit;
    logic [POS_W-1:0] r_rd_addr;
    logic [IDX_W-1:0] restart_value;

    // an entry not written since the last restart reads as its restart value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_hit  <= r_valid[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    // entry i restarts at i; the last entry of the current size is floored
    always_comb begin
        if ((SIZE_W'(r_rd_addr) == i_cur_size - 1'b1) && (i_cur_size > SIZE_W'(1)) &&
            (IDX_W'(i_out_start) > IDX_W'(r_rd_addr))) begin
            restart_value = IDX_W'(i_out_start);
        end else begin
            restart_value = IDX_W'(r_rd_addr);
        end
    end

    assign o_rd_value = r_rd_hit ? r_rd_data : restart_value;

endmodule

`default_nettype wire

[rtl/combination_task_generator_top.sv]
// Top level of the combination task generator: table, sequencer and ports.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a table of up to TABLE_DEPTH variable numbers and hands out the
// combinations of its entries in lexicographic order of strictly increasing
// indices, sizes 1 up to max_length; for sizes above one the last index is
// floored at out_start. Input kind 0 appends var_value (dropped when the table
// is full). Kind 1 returns the next combination as one transaction per
// element, position 0 first, last set on the final one, or a single
// transaction with done_res set and all other fields zero once every size is
// used up. Registers: max_length at byte address 0, out_start at 4; a write
// restarts the enumeration at the current size and is meant for idle time
// only. A request checks the sizes in turn, then streams the elements, scans
// the index vector for the carry and writes it back. The index vector store
// has a single read/write port, which every pass walks one entry per cycle,
// the element stream only while the output side is not stalled. The variable
// table lives in a one-port memory with registered read data. No clearing
// pass follows reset: the index store restarts through its valid bits and
// only written table entries are ever read. The input side stalls from the
// accepted request until its write-back or its done answer is over; the
// output register lets the last element wait while new input is taken.

module combination_task_generator_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_kind,
    input  wire logic [ctg_pkg::DATA_W-1:0]    i_var_value,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [ctg_pkg::DATA_W-1:0]    o_element_value,
    output logic      [3:0]                    o_position,
    output logic      [4:0]                    o_combo_size,
    output logic                               o_last,
    output logic                               o_done_res,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ctg_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ctg_pkg::PDATA_W-1:0]   pwdata,
    output logic      [ctg_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import ctg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK_EV,
        ST_DONE,
        ST_EMIT,
        ST_SCAN,
        ST_WPREP,
        ST_WRITE
    } t_state;

    t_state r_state;

    // configuration and enumeration state
    logic [LEN_W-1:0]  r_max_len;
    logic [OS_W-1:0]   r_out_start;
    logic [CNT_W-1:0]  r_tc;
    logic [SIZE_W-1:0] r_cur;

    // element streaming pipeline
    logic [SIZE_W-1:0] r_cnt;
    logic              r_s1_v;
    logic [POS_W-1:0]  r_s1_pos;
    logic              r_s2_v;
    logic [POS_W-1:0]  r_s2_pos;
    logic              r_s2_zero;

    // carry scan and write-back
    logic              r_iss_left;
    logic [POS_W-1:0]  r_iss_pos;
    logic              r_ev_v;
    logic [POS_W-1:0]  r_ev_pos;
    logic              r_carry;
    logic              r_found;
    logic [POS_W-1:0]  r_m;
    logic [IDX_W-1:0]  r_base;
    logic [IDX_W-1:0]  r_last_new;
    logic [POS_W-1:0]  r_wj;
    logic [IDX_W-1:0]  r_wval;

    // output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic [3:0]        r_out_pos;
    logic [4:0]        r_out_size;
    logic              r_out_last;
    logic              r_out_done;

    // variable table
    logic [DATA_W-1:0] r_var_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] r_var_rdata;

    t_idx_req          idx_req;
    logic [IDX_W-1:0]  idx_rd_value;

    logic              in_accept;
    logic              cfg_write;
    logic              out_en;
    logic              var_we;
    logic              var_re;
    logic [ADDR_W-1:0] var_raddr;
    logic [SIZE_W-1:0] size_lim;
    logic [POS_W-1:0]  kpos;
    logic              used_up;
    logic              scan_top;
    logic              scan_inc;
    logic [IDXC_W-1:0] scan_sum;
    logic              scan_cond;
    logic              wr_floor;

    assign in_accept = i_in_valid && !o_in_stall;
    assign cfg_write = psel && penable && pwrite;
    assign out_en    = !r_out_valid || !i_out_stall;
    assign kpos      = POS_W'(r_cur - 1'b1);

    // max_length 0 acts as 1, above MAX_LEN as MAX_LEN
    always_comb begin
        if (r_max_len == '0) begin
            size_lim = SIZE_W'(1);
        end else if (int'(r_max_len) > MAX_LEN) begin
            size_lim = SIZE_W'(MAX_LEN);
        end else begin
            size_lim = SIZE_W'(r_max_len);
        end
    end

    assign used_up = idx_rd_value >= IDX_W'(r_tc);

    // scan step at position p: index[p] (plus carry) + (k-1-p) reaching the
    // table end carries into p-1
    assign scan_top  = (r_ev_pos == kpos);
    assign scan_inc  = scan_top || r_carry;
    assign scan_sum  = IDXC_W'(idx_rd_value) + IDXC_W'(scan_inc) + IDXC_W'(kpos - r_ev_pos);
    assign scan_cond = scan_sum >= IDXC_W'(r_tc);

    assign wr_floor = (r_wj == kpos) && (r_cur > SIZE_W'(1)) &&
                      (r_wval < IDX_W'(r_out_start));

    // index store access per state
    always_comb begin
        idx_req         = '0;
        idx_req.clear   = cfg_write;
        idx_req.wr_addr = r_wj;
        idx_req.wr_data = wr_floor ? IDX_W'(r_out_start) : r_wval;
        unique case (r_state)
            ST_CHK_RD: begin
                idx_req.rd_en   = 1'b1;
                idx_req.rd_addr = kpos;
            end
            ST_CHK_EV: begin
                idx_req.clear = used_up && (r_cur < size_lim);
            end
            ST_EMIT: begin
                idx_req.rd_en   = out_en && (r_cnt < r_cur);
                idx_req.rd_addr = POS_W'(r_cnt);
            end
            ST_SCAN: begin
                idx_req.rd_en   = r_iss_left;
                idx_req.rd_addr = r_iss_pos;
            end
            ST_WRITE: begin
                idx_req.wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    ctg_idx_mem u_idx_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (idx_req),
        .i_cur_size  (r_cur),
        .i_out_start (r_out_start),
        .o_rd_value  (idx_rd_value)
    );

    // variable table: appends write, the streaming pipeline reads
    assign var_we    = in_accept && (i_kind == KIND_APPEND) && (r_tc < CNT_W'(TABLE_DEPTH));
    assign var_re    = (r_state == ST_EMIT) && out_en && r_s1_v;
    assign var_raddr = ADDR_W'(idx_rd_value);

    always_ff @(posedge i_clk) begin
        if (var_we) begin
            r_var_mem[ADDR_W'(r_tc)] <= i_var_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (var_re) begin
            r_var_rdata <= r_var_mem[var_raddr];
        end
    end

    // sequencer, configuration registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_max_len   <= LEN_W'(1);
            r_out_start <= '0;
            r_tc        <= '0;
            r_cur       <= SIZE_W'(1);
            r_cnt       <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_iss_left  <= 1'b0;
            r_ev_v      <= 1'b0;
            r_carry     <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_write) begin
                if (paddr[2] == REG_OUT_START) begin
                    r_out_start <= pwdata[OS_W-1:0];
                end else begin
                    r_max_len <= pwdata[LEN_W-1:0];
                end
            end

            if (var_we) begin
                r_tc <= r_tc + 1'b1;
            end

            // output register: streamed element or done answer
            if (out_en) begin
                r_out_valid <= r_s2_v || (r_state == ST_DONE);
                if (r_s2_v) begin
                    r_out_value <= r_s2_zero ? '0 : r_var_rdata;
                    r_out_pos   <= 4'(r_s2_pos);
                    r_out_size  <= 5'(r_cur);
                    r_out_last  <= (r_s2_pos == kpos);
                    r_out_done  <= 1'b0;
                end else begin
                    r_out_value <= '0;
                    r_out_pos   <= '0;
                    r_out_size  <= '0;
                    r_out_last  <= 1'b0;
                    r_out_done  <= 1'b1;
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept && (i_kind == KIND_REQUEST)) begin
                        r_state <= ST_CHK_RD;
                    end
                end
                ST_CHK_RD: begin
                    r_state <= ST_CHK_EV;
                end
                ST_CHK_EV: begin
                    if (used_up) begin
                        if (r_cur < size_lim) begin
                            r_cur   <= r_cur + 1'b1;
                            r_state <= ST_CHK_RD;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_cnt   <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_DONE: begin
                    if (out_en) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_en) begin
                        r_s1_v    <= r_cnt < r_cur;
                        r_s1_pos  <= POS_W'(r_cnt);
                        r_s2_v    <= r_s1_v;
                        r_s2_pos  <= r_s1_pos;
                        r_s2_zero <= used_up;
                        if (r_cnt < r_cur) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    if ((r_cnt == r_cur) && !r_s1_v && !r_s2_v) begin
                        r_iss_left <= 1'b1;
                        r_iss_pos  <= kpos;
                        r_ev_v     <= 1'b0;
                        r_carry    <= 1'b0;
                        r_found    <= 1'b0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // walk the index vector downward, one read per cycle
                    r_ev_v   <= r_iss_left;
                    r_ev_pos <= r_iss_pos;
                    if (r_iss_left) begin
                        if (r_iss_pos == '0) begin
                            r_iss_left <= 1'b0;
                        end else begin
                            r_iss_pos <= r_iss_pos - 1'b1;
                        end
                    end
                    if (r_ev_v) begin
                        if (scan_top) begin
                            r_last_new <= IDX_W'(idx_rd_value + 1'b1);
                        end
                        // carried into this entry: the new base of the tail
                        if (r_carry) begin
                            r_base <= IDX_W'(idx_rd_value + 1'b1);
                        end
                        if (r_ev_pos != '0) begin
                            r_carry <= scan_cond;
                            if (scan_cond) begin
                                r_found <= 1'b1;
                                r_m     <= r_ev_pos;
                            end
                        end else begin
                            r_carry <= 1'b0;
                            r_state <= ST_WPREP;
                        end
                    end
                end
                ST_WPREP: begin
                    // lowest carry m rewrites m-1 .. k-1 as a run from the base
                    if (r_found) begin
                        r_wj   <= r_m - 1'b1;
                        r_wval <= r_base;
                    end else begin
                        r_wj   <= kpos;
                        r_wval <= r_last_new;
                    end
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    if (r_wj == kpos) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_wj   <= r_wj + 1'b1;
                        r_wval <= r_wval + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_element_value = r_out_value;
    assign o_position      = r_out_pos;
    assign o_combo_size    = r_out_size;
    assign o_last          = r_out_last;
    assign o_done_res      = r_out_done;

    assign prdata = (paddr[2] == REG_OUT_START) ? PDATA_W'(r_out_start) : PDATA_W'(r_max_len);
    assign pready = 1'b1;

endmodule

`default_nettype wire

[rtl/ctg_checker.sv]
// Port-level checks of the combination task generator and their bind.
`timescale 1ns / 1ps
`default_nettype none

module ctg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_kind,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_element_value,
    input wire logic [3:0]  o_position,
    input wire logic [4:0]  o_combo_size,
    input wire logic        o_last,
    input wire logic        o_done_res
);
    import ctg_pkg::*;

    // a result waiting on a stall holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_element_value) &&
        $stable(o_position) && $stable(o_last) && $stable(o_done_res))
        else $error("output transaction changed while stalled");

    // an accepted request blocks the input side for its run
    a_req_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_kind == KIND_REQUEST) |=> o_in_stall)
        else $error("input not stalled after request");

    // while a combination is only partly out, no new input is taken
    a_stream_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && !o_done_res |-> o_in_stall)
        else $error("input taken in the middle of a combination");

    // last marks exactly the final position of the combination
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |->
        (o_combo_size != 5'd0) && (o_last == ({1'b0, o_position} == o_combo_size - 5'd1)))
        else $error("last marker does not match position");

endmodule

bind combination_task_generator_top ctg_checker u_ctg_checker (.*);

`default_nettype wire
